>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("bpc: property violated");

// Condition must never be seen outside reset.
`define BPC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("bpc: forbidden condition seen");

`endif

>>> hdl/bpc_pkg.sv
package bpc_pkg;

	// APB address width: six word registers
	localparam int AddrW = 5;

	// Register indexes (paddr[4:2])
	localparam logic [2:0] REG_SENS     = 3'd0;
	localparam logic [2:0] REG_OFFSET   = 3'd1;
	localparam logic [2:0] REG_SENS_TC  = 3'd2;
	localparam logic [2:0] REG_OFF_TC   = 3'd3;
	localparam logic [2:0] REG_REF_TEMP = 3'd4;
	localparam logic [2:0] REG_TEMP_TC  = 3'd5;

	// Compensation constants
	localparam int TEMP_REF  = 2000;   // 20.00 C
	localparam int TEMP_VLOW = -1500;  // -15.00 C
	localparam int P_MIN     = 1000;
	localparam int P_MAX     = 120000;
	localparam int TEMP_SHR  = 23;
	localparam int T2_SHR    = 31;

	localparam int OffW = 41;

	// Calibration words
	typedef struct packed {
		logic [15:0] sens;      // C1
		logic [15:0] offset;    // C2
		logic [15:0] sens_tc;   // C3
		logic [15:0] off_tc;    // C4
		logic [15:0] ref_temp;  // C5
		logic [15:0] temp_tc;   // C6
	} cal_t;

	// Fully corrected terms handed to the pressure stages
	typedef struct packed {
		logic signed [18:0]     temp;
		logic signed [OffW-1:0] off;
		logic signed [OffW-1:0] sens;
		logic [23:0]            raw_p;
	} comp_t;

endpackage

>>> hdl/bpc_ifs.sv
// Raw sample channel
interface bpc_in_if;
	logic        valid;
	logic        ready;
	logic [23:0] raw_pressure;
	logic [23:0] raw_temperature;

	modport source(output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// Compensated result channel
interface bpc_out_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] temperature;
	logic [31:0]        pressure;
	logic               out_of_range;

	modport source(output valid, output temperature, output pressure, output out_of_range,
		input ready);
	modport sink(input valid, input temperature, input pressure, input out_of_range,
		output ready);
endinterface

>>> hdl/barometer_pressure_compensation.sv
// Second-order barometric pressure compensation.
// Six 16-bit calibration words are written over the APB port (word i at
// byte address 4*i, pready always high, reads return the word). Write them
// while no item is in flight.
// The sample channel takes one raw pressure / raw temperature pair per item;
// the result channel returns the temperature in hundredths of a degree, the
// pressure in pascal (low 32 bits) and an out-of-range flag.
// Ten register stages lie between accepting an item and showing its result.
// Throughput: one item per cycle while the receiver takes results, set by
// the ten-stage pipeline; the 66-bit product is split into two partial
// products over two stages.
// Reset clears the calibration words to zero and empties the pipeline.
// When the receiver stalls, the result holds in the output register and
// the pipeline keeps taking items until every stage is full; only then
// does the sample channel drop ready. Nothing is lost or repeated.
module barometer_pressure_compensation (
	input  logic                      clk,
	input  logic                      arst_n,
	bpc_in_if.sink                    sample,
	bpc_out_if.source                 result,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bpc_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	bpc_pkg::cal_t  cal;
	bpc_pkg::comp_t comp;
	logic           comp_valid;
	logic           comp_ready;

	bpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	bpc_coef_pipe u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal),
		.sample    (sample),
		.out_valid (comp_valid),
		.out_ready (comp_ready),
		.out_data  (comp)
	);

	bpc_pres_pipe u_pres (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (comp_valid),
		.in_ready (comp_ready),
		.in_data  (comp),
		.result   (result)
	);

endmodule

>>> hdl/bpc_regs.sv
module bpc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bpc_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output bpc_pkg::cal_t              cal
);

	bpc_pkg::cal_t cal_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[bpc_pkg::AddrW-1:2];
	assign cal    = cal_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			case (idx)
				bpc_pkg::REG_SENS:     cal_q.sens     <= pwdata[15:0];
				bpc_pkg::REG_OFFSET:   cal_q.offset   <= pwdata[15:0];
				bpc_pkg::REG_SENS_TC:  cal_q.sens_tc  <= pwdata[15:0];
				bpc_pkg::REG_OFF_TC:   cal_q.off_tc   <= pwdata[15:0];
				bpc_pkg::REG_REF_TEMP: cal_q.ref_temp <= pwdata[15:0];
				bpc_pkg::REG_TEMP_TC:  cal_q.temp_tc  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			bpc_pkg::REG_SENS:     prdata = {16'h0000, cal_q.sens};
			bpc_pkg::REG_OFFSET:   prdata = {16'h0000, cal_q.offset};
			bpc_pkg::REG_SENS_TC:  prdata = {16'h0000, cal_q.sens_tc};
			bpc_pkg::REG_OFF_TC:   prdata = {16'h0000, cal_q.off_tc};
			bpc_pkg::REG_REF_TEMP: prdata = {16'h0000, cal_q.ref_temp};
			bpc_pkg::REG_TEMP_TC:  prdata = {16'h0000, cal_q.temp_tc};
			default:               prdata = '0;
		endcase
	end

endmodule

>>> hdl/bpc_coef_pipe.sv
// Stages 1..6: dT, first-order terms, second-order corrections.
module bpc_coef_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  bpc_pkg::cal_t  cal,
	bpc_in_if.sink         sample,
	output logic           out_valid,
	input  logic           out_ready,
	output bpc_pkg::comp_t out_data
);

	localparam int NumStg = 6;
	localparam int OffW   = bpc_pkg::OffW;
	// TEMP < -1500 expressed on d = TEMP - 2000
	localparam logic signed [18:0] VLOW_D = 19'(bpc_pkg::TEMP_VLOW - bpc_pkg::TEMP_REF);
	localparam logic signed [19:0] TREF   = 20'(bpc_pkg::TEMP_REF);

	logic [NumStg-1:0] vld_q;
	logic [NumStg-1:0] en;
	logic [NumStg-1:0] vld_in;

	// Stage enables: a stage loads when empty or when the next one moves
	always_comb begin
		en[NumStg-1] = !vld_q[NumStg-1] || out_ready;
		for (int k = NumStg - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in       = {vld_q[NumStg-2:0], sample.valid};
	assign sample.ready = en[0];
	assign out_valid    = vld_q[NumStg-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NumStg; k++) begin
				if (en[k]) vld_q[k] <= vld_in[k];
			end
		end
	end

	// S1: dT = raw_t - C5 * 256
	logic signed [24:0] dt_s1;
	logic [23:0]        rawp_s1;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dt_s1   <= $signed({1'b0, sample.raw_temperature}) -
				$signed({1'b0, cal.ref_temp, 8'h00});
			rawp_s1 <= sample.raw_pressure;
		end
	end

	// S2: products with dT
	logic signed [41:0] tc_s2, oc_s2, sc_s2;
	logic signed [49:0] dtsq_s2;
	logic [23:0]        rawp_s2;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			tc_s2   <= dt_s1 * $signed({1'b0, cal.temp_tc});
			oc_s2   <= dt_s1 * $signed({1'b0, cal.off_tc});
			sc_s2   <= dt_s1 * $signed({1'b0, cal.sens_tc});
			dtsq_s2 <= dt_s1 * dt_s1;
			rawp_s2 <= rawp_s1;
		end
	end

	// S3: first-order TEMP, OFF, SENS; T2; low-temperature flags
	logic signed [18:0]     d_c, e_c;
	logic signed [19:0]     temp1_c;
	logic signed [OffW-1:0] off1_c, sens1_c;

	assign d_c     = tc_s2[41:bpc_pkg::TEMP_SHR];
	assign e_c     = d_c - VLOW_D;
	assign temp1_c = {d_c[18], d_c} + TREF;
	assign off1_c  = $signed({9'h000, cal.offset, 16'h0000}) +
		$signed({{6{oc_s2[41]}}, oc_s2[41:7]});
	assign sens1_c = $signed({10'h000, cal.sens, 15'h0000}) +
		$signed({{7{sc_s2[41]}}, sc_s2[41:8]});

	logic signed [18:0]     d_s3, e_s3;
	logic signed [19:0]     temp1_s3;
	logic signed [OffW-1:0] off1_s3, sens1_s3;
	logic [17:0]            t2_s3;
	logic                   lt_s3, vlt_s3;
	logic [23:0]            rawp_s3;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			d_s3     <= d_c;
			e_s3     <= e_c;
			temp1_s3 <= temp1_c;
			off1_s3  <= off1_c;
			sens1_s3 <= sens1_c;
			t2_s3    <= dtsq_s2[bpc_pkg::T2_SHR+17:bpc_pkg::T2_SHR];
			lt_s3    <= d_c[18];
			vlt_s3   <= d_c < VLOW_D;
			rawp_s3  <= rawp_s2;
		end
	end

	// S4: squares for the corrections
	logic signed [37:0]     dsq_s4, esq_s4;
	logic signed [19:0]     temp1_s4;
	logic signed [OffW-1:0] off1_s4, sens1_s4;
	logic [17:0]            t2_s4;
	logic                   lt_s4, vlt_s4;
	logic [23:0]            rawp_s4;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			dsq_s4   <= d_s3 * d_s3;
			esq_s4   <= e_s3 * e_s3;
			temp1_s4 <= temp1_s3;
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			t2_s4    <= t2_s3;
			lt_s4    <= lt_s3;
			vlt_s4   <= vlt_s3;
			rawp_s4  <= rawp_s3;
		end
	end

	// S5: OFF2, SENS2 (both non-negative) and TEMP - T2
	logic signed [OffW-1:0] dsq_x, esq_x, dsq5, esq7, esq11;
	logic signed [OffW-1:0] off2_lo, sens2_lo, off2_vlo, sens2_vlo, off2_c, sens2_c;
	logic signed [19:0]     temp_c;

	assign dsq_x     = {{(OffW-38){dsq_s4[37]}}, dsq_s4};
	assign esq_x     = {{(OffW-38){esq_s4[37]}}, esq_s4};
	assign dsq5      = (dsq_x <<< 2) + dsq_x;
	assign esq7      = (esq_x <<< 3) - esq_x;
	assign esq11     = (esq_x <<< 3) + (esq_x <<< 1) + esq_x;
	assign off2_lo   = dsq5 >>> 1;
	assign sens2_lo  = dsq5 >>> 2;
	assign off2_vlo  = vlt_s4 ? esq7 : '0;
	assign sens2_vlo = vlt_s4 ? (esq11 >>> 1) : '0;

	always_comb begin
		if (lt_s4) begin
			off2_c  = off2_lo + off2_vlo;
			sens2_c = sens2_lo + sens2_vlo;
			temp_c  = temp1_s4 - $signed({2'b00, t2_s4});
		end else begin
			off2_c  = '0;
			sens2_c = '0;
			temp_c  = temp1_s4;
		end
	end

	logic signed [OffW-1:0] off1_s5, sens1_s5, off2_s5, sens2_s5;
	logic signed [19:0]     temp_s5;
	logic [23:0]            rawp_s5;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			temp_s5  <= temp_c;
			rawp_s5  <= rawp_s4;
		end
	end

	// S6: final OFF and SENS
	bpc_pkg::comp_t comp_s6;
	always_ff @(posedge clk) begin
		if (en[5]) begin
			comp_s6.temp  <= temp_s5[18:0];
			comp_s6.off   <= off1_s5 - off2_s5;
			comp_s6.sens  <= sens1_s5 - sens2_s5;
			comp_s6.raw_p <= rawp_s5;
		end
	end

	assign out_data = comp_s6;

endmodule

>>> hdl/bpc_pres_pipe.sv
// Stages 7..10: P = ((D1 * SENS >> 21) - OFF) >> 15, range flag, output register.
module bpc_pres_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bpc_pkg::comp_t in_data,
	bpc_out_if.source      result
);

	localparam int NumStg = 4;
	localparam int OffW   = bpc_pkg::OffW;

	logic [NumStg-1:0] vld_q;
	logic [NumStg-1:0] en;
	logic [NumStg-1:0] vld_in;

	always_comb begin
		en[NumStg-1] = !vld_q[NumStg-1] || result.ready;
		for (int k = NumStg - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in       = {vld_q[NumStg-2:0], in_valid};
	assign in_ready     = en[0];
	assign result.valid = vld_q[NumStg-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NumStg; k++) begin
				if (en[k]) vld_q[k] <= vld_in[k];
			end
		end
	end

	// S7: D1 * SENS split into two partial products on SENS
	logic [43:0]            lo_s7;
	logic signed [45:0]     hi_s7;
	logic signed [OffW-1:0] off_s7;
	logic signed [18:0]     temp_s7;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			lo_s7   <= in_data.raw_p * in_data.sens[19:0];
			hi_s7   <= $signed({1'b0, in_data.raw_p}) * $signed(in_data.sens[OffW-1:20]);
			off_s7  <= in_data.off;
			temp_s7 <= in_data.temp;
		end
	end

	// S8: recombine the full product
	logic signed [65:0]     prod_s8;
	logic signed [OffW-1:0] off_s8;
	logic signed [18:0]     temp_s8;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s8 <= $signed(({{20{hi_s7[45]}}, hi_s7} << 20) + {22'h0, lo_s7});
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// S9: subtract OFF, floor shift by 15, keep low 32 bits
	logic signed [47:0] q_c;
	assign q_c = $signed({{3{prod_s8[65]}}, prod_s8[65:21]}) -
		$signed({{(48-OffW){off_s8[OffW-1]}}, off_s8});

	logic [31:0]        pres_s9;
	logic signed [18:0] temp_s9;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			pres_s9 <= q_c[46:15];
			temp_s9 <= temp_s8;
		end
	end

	// S10: output register with range flag
	always_ff @(posedge clk) begin
		if (en[3]) begin
			result.pressure     <= pres_s9;
			result.temperature  <= temp_s9;
			result.out_of_range <= (pres_s9 < 32'(bpc_pkg::P_MIN)) ||
				(pres_s9 > 32'(bpc_pkg::P_MAX));
		end
	end

endmodule

>>> hdl/bpc_checker.sv
`include "assert_macros.svh"

module bpc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [18:0] out_temperature,
	input logic [31:0]        out_pressure,
	input logic               out_of_range
);

	logic        out_stall;
	logic        range_bad;
	logic [51:0] out_item;

	assign out_stall = out_valid && !out_ready;
	assign range_bad = (out_pressure < 32'(bpc_pkg::P_MIN)) ||
		(out_pressure > 32'(bpc_pkg::P_MAX));
	assign out_item  = {out_temperature, out_pressure, out_of_range};

	// A stalled result stays put
	`BPC_ASSERT(a_out_hold, clk, arst_n, out_stall |=> out_valid && $stable(out_item))

	// Range flag agrees with the pressure shown
	`BPC_ASSERT(a_range_flag, clk, arst_n, out_valid |-> out_of_range == range_bad)

	// Input backpressure only when the result side is stalled
	`BPC_ASSERT(a_full_only, clk, arst_n, !in_ready |-> out_stall)

	// Output is never valid just after reset
	`BPC_NEVER(a_no_ghost, clk, arst_n, out_valid && !$past(arst_n))

endmodule

bind barometer_pressure_compensation bpc_checker u_bpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (sample.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.out_temperature (result.temperature),
	.out_pressure    (result.pressure),
	.out_of_range    (result.out_of_range)
);
